@@ hw/rtl/sckl_pkg.sv @@
`timescale 1ns / 1ps

package sckl_pkg;

   localparam int CAPACITY   = 32;
   localparam int KEY_BITS   = 64;
   localparam int COUNT_BITS = 16;

   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int LVL_BITS = $clog2(CAPACITY + 1);
   localparam int CAP_BITS = 6;

   // stream word widths, padded to whole bytes
   localparam int REQ_DATA_BITS = ((KEY_BITS + IDX_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((KEY_BITS + COUNT_BITS + LVL_BITS + 1 + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef struct packed {
      logic                we;
      logic [IDX_BITS-1:0] waddr;
      entry_type           wdata;
      logic [IDX_BITS-1:0] raddr;
   } mem_req_type;

endpackage

@@ hw/rtl/sckl_mem.sv @@
`timescale 1ns / 1ps

module sckl_mem (
   input  logic                   clock,
   input  sckl_pkg::mem_req_type  mem_req,
   output sckl_pkg::entry_type    mem_rdata
);

   sckl_pkg::entry_type mem_ff [sckl_pkg::CAPACITY];
   sckl_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem_ff[mem_req.raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

@@ hw/rtl/sckl_ctrl.sv @@
`timescale 1ns / 1ps

module sckl_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sckl_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sckl_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [sckl_pkg::CAP_BITS-1:0]        csr_wdata,
   output sckl_pkg::mem_req_type                mem_req,
   input  sckl_pkg::entry_type                  mem_rdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHUP,
      ST_INS,
      ST_SHDN,
      ST_RD,
      ST_DONE
   } state_type;

   localparam logic [sckl_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [sckl_pkg::LVL_BITS-1:0]   ONE_LVL   = sckl_pkg::LVL_BITS'(1);
   localparam logic [sckl_pkg::LVL_BITS-1:0]   TWO_LVL   = sckl_pkg::LVL_BITS'(2);

   state_type                           state_ff, state_in;
   logic [sckl_pkg::LVL_BITS-1:0]       fill_ff, fill_in;
   logic [sckl_pkg::CAP_BITS-1:0]       cap_ff, cap_in;
   sckl_pkg::action_type                act_ff, act_in;
   logic [sckl_pkg::KEY_BITS-1:0]       key_ff, key_in;
   logic [sckl_pkg::LVL_BITS-1:0]       scan_ff, scan_in;
   logic [sckl_pkg::LVL_BITS-1:0]       pos_ff, pos_in;
   logic                                hit_ff, hit_in;
   logic [sckl_pkg::COUNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [sckl_pkg::LVL_BITS-1:0]       sh_ff, sh_in;
   logic                                res_ok_ff, res_ok_in;
   logic [sckl_pkg::KEY_BITS-1:0]       res_key_ff, res_key_in;
   logic [sckl_pkg::COUNT_BITS-1:0]     res_cnt_ff, res_cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_ok_ff, rsp_ok_in;
   logic [sckl_pkg::KEY_BITS-1:0]       rsp_key_ff, rsp_key_in;
   logic [sckl_pkg::COUNT_BITS-1:0]     rsp_cnt_ff, rsp_cnt_in;
   logic [sckl_pkg::LVL_BITS-1:0]       rsp_occ_ff, rsp_occ_in;

   logic [sckl_pkg::KEY_BITS-1:0]       req_key;
   logic [sckl_pkg::IDX_BITS-1:0]       req_idx;
   logic [sckl_pkg::CAP_BITS-1:0]       limit;

   assign req_key    = req_tdata[sckl_pkg::KEY_BITS-1:0];
   assign req_idx    = req_tdata[sckl_pkg::KEY_BITS +: sckl_pkg::IDX_BITS];
   assign req_tready = (state_ff == ST_IDLE);

   assign limit = (cap_ff < sckl_pkg::CAP_BITS'(sckl_pkg::CAPACITY)) ?
                  cap_ff : sckl_pkg::CAP_BITS'(sckl_pkg::CAPACITY);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      scan_in      = scan_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      sh_in        = sh_ff;
      res_ok_in    = res_ok_ff;
      res_key_in   = res_key_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_occ_in   = rsp_occ_ff;
      mem_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in     = sckl_pkg::action_type'(req_tuser);
               key_in     = req_key;
               res_ok_in  = 1'b0;
               res_key_in = '0;
               res_cnt_in = '0;
               state_in   = ST_DONE;
               unique case (sckl_pkg::action_type'(req_tuser))
                  sckl_pkg::ACT_ADD, sckl_pkg::ACT_REMOVE: begin
                     if (fill_ff == '0) begin
                        pos_in   = '0;
                        hit_in   = 1'b0;
                        state_in = ST_DECIDE;
                     end else begin
                        mem_req.raddr = '0;
                        scan_in       = ONE_LVL;
                        state_in      = ST_SCAN;
                     end
                  end
                  sckl_pkg::ACT_READ: begin
                     if (sckl_pkg::LVL_BITS'(req_idx) < fill_ff) begin
                        mem_req.raddr = req_idx;
                        state_in      = ST_RD;
                     end
                  end
                  sckl_pkg::ACT_NONE: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // descending order: the first entry not above the key is its place
         ST_SCAN: begin
            if (mem_rdata.key <= key_ff) begin
               pos_in   = scan_ff - ONE_LVL;
               hit_in   = (mem_rdata.key == key_ff);
               cnt_in   = mem_rdata.count;
               state_in = ST_DECIDE;
            end else if (scan_ff == fill_ff) begin
               pos_in   = fill_ff;
               hit_in   = 1'b0;
               state_in = ST_DECIDE;
            end else begin
               mem_req.raddr = scan_ff[sckl_pkg::IDX_BITS-1:0];
               scan_in       = scan_ff + ONE_LVL;
            end
         end

         ST_DECIDE: begin
            state_in = ST_DONE;
            if (act_ff == sckl_pkg::ACT_ADD) begin
               if (hit_ff) begin
                  mem_req.we          = 1'b1;
                  mem_req.waddr       = pos_ff[sckl_pkg::IDX_BITS-1:0];
                  mem_req.wdata.key   = key_ff;
                  mem_req.wdata.count = (cnt_ff == COUNT_MAX) ? cnt_ff :
                                        cnt_ff + sckl_pkg::COUNT_BITS'(1);
                  res_ok_in           = 1'b1;
                  res_key_in          = key_ff;
                  res_cnt_in          = mem_req.wdata.count;
               end else if (fill_ff >= sckl_pkg::LVL_BITS'(limit)) begin
                  res_ok_in = 1'b0;
               end else if (pos_ff == fill_ff) begin
                  state_in = ST_INS;
               end else begin
                  mem_req.raddr = fill_in[sckl_pkg::IDX_BITS-1:0] -
                                  sckl_pkg::IDX_BITS'(1);
                  sh_in         = fill_ff;
                  state_in      = ST_SHUP;
               end
            end else begin
               if (!hit_ff) begin
                  res_ok_in = 1'b0;
               end else if (cnt_ff > sckl_pkg::COUNT_BITS'(1)) begin
                  mem_req.we          = 1'b1;
                  mem_req.waddr       = pos_ff[sckl_pkg::IDX_BITS-1:0];
                  mem_req.wdata.key   = key_ff;
                  mem_req.wdata.count = cnt_ff - sckl_pkg::COUNT_BITS'(1);
                  res_ok_in           = 1'b1;
                  res_key_in          = key_ff;
                  res_cnt_in          = mem_req.wdata.count;
               end else begin
                  res_ok_in  = 1'b1;
                  res_key_in = key_ff;
                  res_cnt_in = '0;
                  if (pos_ff + ONE_LVL < fill_ff) begin
                     mem_req.raddr = pos_ff[sckl_pkg::IDX_BITS-1:0] +
                                     sckl_pkg::IDX_BITS'(1);
                     sh_in         = pos_ff;
                     state_in      = ST_SHDN;
                  end else begin
                     fill_in = fill_ff - ONE_LVL;
                  end
               end
            end
         end

         // move entries up one place, top first, to open the insert slot
         ST_SHUP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = sh_ff[sckl_pkg::IDX_BITS-1:0];
            mem_req.wdata = mem_rdata;
            if (sh_ff - ONE_LVL == pos_ff) begin
               state_in = ST_INS;
            end else begin
               mem_req.raddr = sh_ff[sckl_pkg::IDX_BITS-1:0] - sckl_pkg::IDX_BITS'(2);
               sh_in         = sh_ff - ONE_LVL;
            end
         end

         ST_INS: begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = pos_ff[sckl_pkg::IDX_BITS-1:0];
            mem_req.wdata.key   = key_ff;
            mem_req.wdata.count = sckl_pkg::COUNT_BITS'(1);
            fill_in             = fill_ff + ONE_LVL;
            res_ok_in           = 1'b1;
            res_key_in          = key_ff;
            res_cnt_in          = sckl_pkg::COUNT_BITS'(1);
            state_in            = ST_DONE;
         end

         // close the gap left by a deleted key
         ST_SHDN: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = sh_ff[sckl_pkg::IDX_BITS-1:0];
            mem_req.wdata = mem_rdata;
            if (sh_ff + TWO_LVL < fill_ff) begin
               mem_req.raddr = sh_ff[sckl_pkg::IDX_BITS-1:0] + sckl_pkg::IDX_BITS'(2);
               sh_in         = sh_ff + ONE_LVL;
            end else begin
               fill_in  = fill_ff - ONE_LVL;
               state_in = ST_DONE;
            end
         end

         ST_RD: begin
            res_ok_in  = 1'b1;
            res_key_in = mem_rdata.key;
            res_cnt_in = mem_rdata.count;
            state_in   = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_key_in   = res_key_ff;
               rsp_cnt_in   = res_cnt_ff;
               rsp_occ_in   = fill_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cap_ff       <= sckl_pkg::CAP_BITS'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff     <= act_in;
      key_ff     <= key_in;
      scan_ff    <= scan_in;
      pos_ff     <= pos_in;
      hit_ff     <= hit_in;
      cnt_ff     <= cnt_in;
      sh_ff      <= sh_in;
      res_ok_ff  <= res_ok_in;
      res_key_ff <= res_key_in;
      res_cnt_ff <= res_cnt_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_key_ff <= rsp_key_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = sckl_pkg::RSP_DATA_BITS'({(rsp_occ_ff != '0), rsp_occ_ff,
                                                rsp_cnt_ff, rsp_key_ff});

endmodule

@@ hw/rtl/sorted_counted_key_list.sv @@
`timescale 1ns / 1ps

// Sorted list of up to 32 distinct 64-bit keys, largest first, each with a
// 16-bit saturating count, held in one single-port-read, single-port-write
// memory with registered read data. One word in, one word out, one at a time.
// An add or remove scans from the top entry, one read a cycle, until it meets
// a key not above its own or the end of the list; an insert then shifts the
// lower entries up and a delete shifts them back, one entry a cycle. The
// memory port, one access a cycle, sets this pace. A new word is taken while
// the previous answer still waits on the output register. Entries are never
// cleared, so no pass is needed after reset; capacity_limit resets to 32.
module sorted_counted_key_list (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // key, entry_index, zero pad
   input  logic [sckl_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // action
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // entry_key, entry_count, occupancy, nonempty, zero pad
   output logic [sckl_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // ok
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [sckl_pkg::CAP_BITS-1:0]        csr_wdata
);

   sckl_pkg::mem_req_type mem_req;
   sckl_pkg::entry_type   mem_rdata;

   sckl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   sckl_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

endmodule
